FILE: rtl/acpp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the affine camera point projection core.
// No dependencies.
package acpp_pkg;

    localparam int W = 32;
    localparam int QW = 64;
    localparam int DIV_STEPS = 32;
    localparam int NUM_REGS = 7;
    localparam int IDX_W = 3;

    localparam logic OP_PROJECT = 1'b0;
    localparam logic OP_RESCALE = 1'b1;

    localparam logic ST_OK = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

    localparam logic [IDX_W-1:0] REG_HOMOG_SCALE = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_SKEW_XY = 3'd5;
    localparam logic [IDX_W-1:0] REG_SKEW_YX = 3'd6;

    localparam logic [W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [W-1:0] S32_MIN = 32'h8000_0000;

    // sideband that travels next to the division lanes
    typedef struct packed {
        logic op;
        logic zero;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_side;

    // divisor magnitude and both partial remainder / quotient lanes
    typedef struct packed {
        logic [W-1:0] dvs;
        logic [W-1:0] rem_x;
        logic [W-1:0] low_x;
        logic [W-1:0] rem_y;
        logic [W-1:0] low_y;
    } t_div;

    typedef struct packed {
        logic [W-1:0] homog_scale;
        logic [W-1:0] focal_x;
        logic [W-1:0] focal_y;
        logic [W-1:0] centre_x;
        logic [W-1:0] centre_y;
        logic [W-1:0] skew_xy;
        logic [W-1:0] skew_yx;
    } t_cfg;

    function automatic logic [W-1:0] sat32(input logic signed [65:0] v);
        logic [W-1:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -66'sh0_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/affine_camera_point_project_core.sv
`timescale 1ns / 1ps
// Top level of the affine camera point projection core: register file and pipeline.
// Depends on acpp_pkg, acpp_front, acpp_div_step and acpp_affine.
//
// Takes one homogeneous Q16.16 point and an operation per beat and returns one result
// beat per input beat, in order. Project divides x and y by z (truncated toward zero,
// saturated), gives those as norm_x/norm_y, and maps them through the affine camera
// matrix (product sum floored to the fraction grid, centre added, saturated). Rescale
// gives zh*x/z, zh*y/z and zh. A zero z gives status 1 with all other fields zero.
// A new point is taken every cycle while the pipeline is not held. It has three front
// stages, 32 one-bit restoring division stages (both lanes side by side), and four
// stages for quotient saturation, the matrix products, the sum and the output
// register. The whole pipeline holds only while the output register is full and
// stalled, so i_valid is taken whenever o_valid is low or i_stall is low. Write
// configuration registers only while the pipeline is empty.
module affine_camera_point_project_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_image_x,
    output logic [31:0] o_image_y,
    output logic [31:0] o_image_w,
    output logic [31:0] o_norm_x,
    output logic [31:0] o_norm_y,
    output logic        o_status
);
    import acpp_pkg::*;

    t_cfg r_cfg;
    logic w_en;
    logic w_v [0:DIV_STEPS];
    t_side w_side [0:DIV_STEPS];
    t_div w_div [0:DIV_STEPS];

    // advance everything unless a finished beat sits stalled at the output
    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.homog_scale <= W'(1) << FRAC_BITS;
            r_cfg.focal_x <= W'(1) << FRAC_BITS;
            r_cfg.focal_y <= W'(1) << FRAC_BITS;
            r_cfg.centre_x <= '0;
            r_cfg.centre_y <= '0;
            r_cfg.skew_xy <= '0;
            r_cfg.skew_yx <= '0;
        end else if (i_cfg_we) begin
            // drop writes to indexes past the register list
            unique case (i_cfg_idx)
                REG_HOMOG_SCALE: r_cfg.homog_scale <= i_cfg_data;
                REG_FOCAL_X:     r_cfg.focal_x <= i_cfg_data;
                REG_FOCAL_Y:     r_cfg.focal_y <= i_cfg_data;
                REG_CENTRE_X:    r_cfg.centre_x <= i_cfg_data;
                REG_CENTRE_Y:    r_cfg.centre_y <= i_cfg_data;
                REG_SKEW_XY:     r_cfg.skew_xy <= i_cfg_data;
                REG_SKEW_YX:     r_cfg.skew_yx <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acpp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_op    (i_operation),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_zh    (r_cfg.homog_scale),
        .o_valid (w_v[0]),
        .o_side  (w_side[0]),
        .o_div   (w_div[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        acpp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_side  (w_side[g]),
            .i_div   (w_div[g]),
            .o_valid (w_v[g+1]),
            .o_side  (w_side[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    acpp_affine #(.FRAC_BITS(FRAC_BITS)) u_affine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_v[DIV_STEPS]),
        .i_side    (w_side[DIV_STEPS]),
        .i_div     (w_div[DIV_STEPS]),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .o_image_x (o_image_x),
        .o_image_y (o_image_y),
        .o_image_w (o_image_w),
        .o_norm_x  (o_norm_x),
        .o_norm_y  (o_norm_y),
        .o_status  (o_status)
    );

endmodule

FILE: rtl/acpp_front.sv
`timescale 1ns / 1ps
// Front of the divider pipeline: dividend forming, magnitudes, overflow check.
// Depends on acpp_pkg.
module acpp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic                     i_op,
    input  logic [31:0]              i_x,
    input  logic [31:0]              i_y,
    input  logic [31:0]              i_z,
    input  logic [31:0]              i_zh,
    output logic                     o_valid,
    output acpp_pkg::t_side          o_side,
    output acpp_pkg::t_div           o_div
);
    import acpp_pkg::*;

    logic signed [QW-1:0] w_shx, w_shy, w_mx, w_my;
    logic r_a_v, r_b_v, r_c_v;
    logic r_a_op, r_b_op;
    logic signed [QW-1:0] r_a_nx, r_a_ny;
    logic [W-1:0] r_a_z;
    logic [QW-1:0] r_b_mx, r_b_my;
    logic [W-1:0] r_b_d;
    logic r_b_zero, r_b_negx, r_b_negy;
    t_side r_c_side;
    t_div r_c_div;

    assign w_shx = $signed({{(QW-W){i_x[W-1]}}, i_x}) <<< FRAC_BITS;
    assign w_shy = $signed({{(QW-W){i_y[W-1]}}, i_y}) <<< FRAC_BITS;
    assign w_mx = $signed(i_zh) * $signed(i_x);
    assign w_my = $signed(i_zh) * $signed(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // form the dividends
            r_a_op <= i_op;
            r_a_nx <= (i_op == OP_RESCALE) ? w_mx : w_shx;
            r_a_ny <= (i_op == OP_RESCALE) ? w_my : w_shy;
            r_a_z <= i_z;
            // take magnitudes, keep quotient signs
            r_b_op <= r_a_op;
            r_b_mx <= r_a_nx[QW-1] ? QW'(-r_a_nx) : r_a_nx;
            r_b_my <= r_a_ny[QW-1] ? QW'(-r_a_ny) : r_a_ny;
            r_b_d <= r_a_z[W-1] ? W'(-r_a_z) : r_a_z;
            r_b_zero <= (r_a_z == '0);
            r_b_negx <= r_a_nx[QW-1] ^ r_a_z[W-1];
            r_b_negy <= r_a_ny[QW-1] ^ r_a_z[W-1];
            // quotient beyond 32 bits saturates regardless of the low steps
            r_c_side.op <= r_b_op;
            r_c_side.zero <= r_b_zero;
            r_c_side.neg_x <= r_b_negx;
            r_c_side.neg_y <= r_b_negy;
            r_c_side.ovf_x <= (r_b_mx[QW-1:W] >= r_b_d);
            r_c_side.ovf_y <= (r_b_my[QW-1:W] >= r_b_d);
            r_c_div.dvs <= r_b_d;
            r_c_div.rem_x <= r_b_mx[QW-1:W];
            r_c_div.low_x <= r_b_mx[W-1:0];
            r_c_div.rem_y <= r_b_my[QW-1:W];
            r_c_div.low_y <= r_b_my[W-1:0];
        end
    end

    assign o_valid = r_c_v;
    assign o_side = r_c_side;
    assign o_div = r_c_div;

endmodule

FILE: rtl/acpp_div_step.sv
`timescale 1ns / 1ps
// One registered restoring-division step for both the x and y lanes.
// Depends on acpp_pkg.
module acpp_div_step (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  acpp_pkg::t_side          i_side,
    input  acpp_pkg::t_div           i_div,
    output logic                     o_valid,
    output acpp_pkg::t_side          o_side,
    output acpp_pkg::t_div           o_div
);
    import acpp_pkg::*;

    logic [W:0] w_tx, w_ty, w_dx, w_dy;
    logic w_gex, w_gey;
    logic r_v;
    t_side r_side;
    t_div r_div;

    assign w_tx = {i_div.rem_x, i_div.low_x[W-1]};
    assign w_ty = {i_div.rem_y, i_div.low_y[W-1]};
    assign w_gex = (w_tx >= {1'b0, i_div.dvs});
    assign w_gey = (w_ty >= {1'b0, i_div.dvs});
    assign w_dx = w_tx - {1'b0, i_div.dvs};
    assign w_dy = w_ty - {1'b0, i_div.dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_div.dvs <= i_div.dvs;
            r_div.rem_x <= w_gex ? w_dx[W-1:0] : w_tx[W-1:0];
            r_div.rem_y <= w_gey ? w_dy[W-1:0] : w_ty[W-1:0];
            r_div.low_x <= {i_div.low_x[W-2:0], w_gex};
            r_div.low_y <= {i_div.low_y[W-2:0], w_gey};
        end
    end

    assign o_valid = r_v;
    assign o_side = r_side;
    assign o_div = r_div;

endmodule

FILE: rtl/acpp_affine.sv
`timescale 1ns / 1ps
// Quotient saturation and the affine camera matrix stages, ending in the output register.
// Depends on acpp_pkg.
module acpp_affine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  acpp_pkg::t_side          i_side,
    input  acpp_pkg::t_div           i_div,
    input  acpp_pkg::t_cfg           i_cfg,
    output logic                     o_valid,
    output logic [31:0]              o_image_x,
    output logic [31:0]              o_image_y,
    output logic [31:0]              o_image_w,
    output logic [31:0]              o_norm_x,
    output logic [31:0]              o_norm_y,
    output logic                     o_status
);
    import acpp_pkg::*;

    logic [W-1:0] w_qx, w_qy;
    logic signed [65:0] w_tx, w_ty;
    logic r_f_v, r_g_v, r_h_v, r_i_v;
    logic r_f_op, r_g_op, r_h_op;
    logic r_f_zero, r_g_zero, r_h_zero;
    logic [W-1:0] r_f_qx, r_f_qy, r_g_qx, r_g_qy, r_h_qx, r_h_qy;
    logic signed [QW-1:0] r_g_p1, r_g_p2, r_g_p3, r_g_p4;
    logic signed [QW:0] r_h_sx, r_h_sy;
    logic [W-1:0] r_ix, r_iy, r_iw, r_nx, r_ny;
    logic r_st;

    function automatic logic [W-1:0] fix_quot(input logic [W-1:0] q, input logic neg,
                                              input logic ovf);
        logic [W-1:0] r;
        if (neg) begin
            r = (ovf || q > S32_MIN) ? S32_MIN : W'(-q);
        end else begin
            r = (ovf || q[W-1]) ? S32_MAX : q;
        end
        return r;
    endfunction

    assign w_qx = fix_quot(i_div.low_x, i_side.neg_x, i_side.ovf_x);
    assign w_qy = fix_quot(i_div.low_y, i_side.neg_y, i_side.ovf_y);

    // floor to the fraction grid, then add the centre term
    assign w_tx = 66'(r_h_sx >>> FRAC_BITS) + $signed({{34{i_cfg.centre_x[W-1]}}, i_cfg.centre_x});
    assign w_ty = 66'(r_h_sy >>> FRAC_BITS) + $signed({{34{i_cfg.centre_y[W-1]}}, i_cfg.centre_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= i_valid;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_op <= i_side.op;
            r_f_zero <= i_side.zero;
            r_f_qx <= w_qx;
            r_f_qy <= w_qy;

            r_g_op <= r_f_op;
            r_g_zero <= r_f_zero;
            r_g_qx <= r_f_qx;
            r_g_qy <= r_f_qy;
            r_g_p1 <= $signed(i_cfg.focal_x) * $signed(r_f_qx);
            r_g_p2 <= $signed(i_cfg.skew_xy) * $signed(r_f_qy);
            r_g_p3 <= $signed(i_cfg.skew_yx) * $signed(r_f_qx);
            r_g_p4 <= $signed(i_cfg.focal_y) * $signed(r_f_qy);

            r_h_op <= r_g_op;
            r_h_zero <= r_g_zero;
            r_h_qx <= r_g_qx;
            r_h_qy <= r_g_qy;
            r_h_sx <= (QW+1)'(r_g_p1) + (QW+1)'(r_g_p2);
            r_h_sy <= (QW+1)'(r_g_p3) + (QW+1)'(r_g_p4);

            // zero divisor clears every field; rescale clears the norm pair
            if (r_h_zero) begin
                r_ix <= '0;
                r_iy <= '0;
                r_iw <= '0;
                r_nx <= '0;
                r_ny <= '0;
                r_st <= ST_DIV_ZERO;
            end else if (r_h_op == OP_RESCALE) begin
                r_ix <= r_h_qx;
                r_iy <= r_h_qy;
                r_iw <= i_cfg.homog_scale;
                r_nx <= '0;
                r_ny <= '0;
                r_st <= ST_OK;
            end else begin
                r_ix <= sat32(w_tx);
                r_iy <= sat32(w_ty);
                r_iw <= i_cfg.homog_scale;
                r_nx <= r_h_qx;
                r_ny <= r_h_qy;
                r_st <= ST_OK;
            end
        end
    end

    assign o_valid = r_i_v;
    assign o_image_x = r_ix;
    assign o_image_y = r_iy;
    assign o_image_w = r_iw;
    assign o_norm_x = r_nx;
    assign o_norm_y = r_ny;
    assign o_status = r_st;

endmodule
